FILE: sv/srr_pkg.sv
// Shared constants, sideband type and fixed-point multiply for the Schlick reflectance unit.
`default_nettype none

package srr_pkg;

	// Internal fractions are unsigned Q1.30.
	localparam int QBITS = 30;
	localparam int Q_W = QBITS + 1;
	localparam int RAD_W = 2 * QBITS + 1;
	localparam logic [Q_W-1:0] QONE = Q_W'(1) << QBITS;
	localparam logic [15:0] REFL_ONE = 16'd32768;
	localparam int REFL_SHIFT = QBITS - 15;

	typedef struct packed {
		logic           tir;
		logic           gt;
		logic           sq_zero;
		logic [Q_W-1:0] c;
		logic [Q_W-1:0] r0;
	} srr_side_t;

	// Q1.30 product, truncated; callers keep both operands at or below 1.0.
	function automatic logic [Q_W-1:0] qmul(input logic [Q_W-1:0] a, input logic [Q_W-1:0] b);
		logic [2*Q_W-1:0] pr;
		pr = a * b;
		return pr[QBITS+Q_W-1:QBITS];
	endfunction

endpackage

`default_nettype wire

FILE: sv/srr_div_pipe.sv
// Pipelined restoring divider, one quotient bit per stage, with sideband.
`default_nettype none

module srr_div_pipe
	import srr_pkg::*;
#(
	parameter int NUM_W = 59,
	parameter int DEN_W = 28,
	parameter int SIDE_W = 2
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  logic [NUM_W-1:0]  num,
	input  logic [DEN_W-1:0]  den,
	input  logic [SIDE_W-1:0] side_in,
	output logic              out_valid,
	output logic [Q_W-1:0]    quo,
	output logic [SIDE_W-1:0] side_out
);

	localparam int CW = (NUM_W > DEN_W + Q_W) ? NUM_W : DEN_W + Q_W;

	logic              vld_s  [Q_W];
	logic [CW-1:0]     rem_s  [Q_W];
	logic [DEN_W-1:0]  den_s  [Q_W];
	logic [Q_W-1:0]    quo_s  [Q_W];
	logic [SIDE_W-1:0] side_s [Q_W];

	for (genvar k = 0; k < Q_W; k++) begin : g_stage
		logic              vld_in;
		logic [CW-1:0]     rem_in;
		logic [CW-1:0]     dsh;
		logic [DEN_W-1:0]  den_in;
		logic [Q_W-1:0]    quo_in;
		logic [SIDE_W-1:0] side_k;
		logic              ge;

		if (k == 0) begin : g_head
			assign vld_in = in_valid;
			assign rem_in = CW'(num);
			assign den_in = den;
			assign quo_in = '0;
			assign side_k = side_in;
		end else begin : g_body
			assign vld_in = vld_s[k-1];
			assign rem_in = rem_s[k-1];
			assign den_in = den_s[k-1];
			assign quo_in = quo_s[k-1];
			assign side_k = side_s[k-1];
		end

		// Trial subtract of the divisor aligned to this quotient bit.
		assign dsh = CW'(den_in) << (Q_W - 1 - k);
		assign ge = rem_in >= dsh;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= vld_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k] <= ge ? rem_in - dsh : rem_in;
				den_s[k] <= den_in;
				quo_s[k] <= quo_in | (Q_W'(ge) << (Q_W - 1 - k));
				side_s[k] <= side_k;
			end
		end
	end

	assign out_valid = vld_s[Q_W-1];
	assign quo = quo_s[Q_W-1];
	assign side_out = side_s[Q_W-1];

endmodule

`default_nettype wire

FILE: sv/srr_sqrt_pipe.sv
// Pipelined integer square root, one root bit per stage, with sideband.
`default_nettype none

module srr_sqrt_pipe
	import srr_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             in_valid,
	input  logic [RAD_W-1:0] rad,
	input  srr_side_t        side_in,
	output logic             out_valid,
	output logic [Q_W-1:0]   root,
	output srr_side_t        side_out
);

	localparam int RW = RAD_W + 1;

	logic          vld_s  [Q_W];
	logic [RW-1:0] v_s    [Q_W];
	logic [RW-1:0] res_s  [Q_W];
	srr_side_t     side_s [Q_W];

	for (genvar k = 0; k < Q_W; k++) begin : g_stage
		logic          vld_in;
		logic [RW-1:0] v_in;
		logic [RW-1:0] res_in;
		logic [RW-1:0] bitv;
		logic [RW-1:0] trial;
		srr_side_t     side_k;
		logic          ge;

		if (k == 0) begin : g_head
			assign vld_in = in_valid;
			assign v_in = RW'(rad);
			assign res_in = '0;
			assign side_k = side_in;
		end else begin : g_body
			assign vld_in = vld_s[k-1];
			assign v_in = v_s[k-1];
			assign res_in = res_s[k-1];
			assign side_k = side_s[k-1];
		end

		assign bitv = RW'(1) << (2 * (Q_W - 1 - k));
		assign trial = res_in + bitv;
		assign ge = v_in >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= vld_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				v_s[k] <= ge ? v_in - trial : v_in;
				res_s[k] <= ge ? (res_in >> 1) + bitv : res_in >> 1;
				side_s[k] <= side_k;
			end
		end
	end

	assign out_valid = vld_s[Q_W-1];
	assign root = res_s[Q_W-1][Q_W-1:0];
	assign side_out = side_s[Q_W-1];

endmodule

`default_nettype wire

FILE: sv/schlick_reflectance_unit.sv
// Top level of the Schlick reflectance unit: dot product, refraction, pow5 and output skid.
//
//  channel | dir | handshake          | payload
//  s_      | in  | s_tvalid/s_tready  | s_tdata: eye xyz, normal xyz, index_from, index_to
//  m_      | out | m_tvalid/m_tready  | m_tdata: reflectance_value; m_tuser: total_internal
//
// One request enters per cycle while s_tready is high; each result passes through 5 front stages,
// the 31-stage divide pair running side by side, the 31-stage square root, 6 back stages and the
// output register.
// All pipeline stages advance together while the two-entry output skid has room.
// arst_n clears every valid bit; payload registers are not reset.
// s_tready depends only on registered state.
`default_nettype none

module schlick_reflectance_unit
	import srr_pkg::*;
#(
	parameter int VECTOR_FRAC_BITS = 14
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// [15:0] eye_x, [31:16] eye_y, [47:32] eye_z, [63:48] normal_x, [79:64] normal_y,
	// [95:80] normal_z, [109:96] index_from, [123:110] index_to, [127:124] zero
	input  logic [127:0] s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// [15:0] reflectance_value
	output logic [15:0]  m_tdata,
	// [0] total_internal
	output logic [0:0]   m_tuser
);

	localparam int F = VECTOR_FRAC_BITS;
	localparam int DOT_W = 34;
	localparam int CW = (2 * F + 2 > DOT_W) ? 2 * F + 2 : DOT_W;
	localparam logic signed [CW-1:0] ONE2F = CW'(1) << (2 * F);
	localparam logic [2*Q_W-1:0] ONE_SQ = (2 * Q_W)'(1) << (2 * QBITS);

	logic en;

	// Input fields
	logic signed [15:0] eye_x, eye_y, eye_z, normal_x, normal_y, normal_z;
	logic [13:0] index_from, index_to;

	assign eye_x = s_tdata[15:0];
	assign eye_y = s_tdata[31:16];
	assign eye_z = s_tdata[47:32];
	assign normal_x = s_tdata[63:48];
	assign normal_y = s_tdata[79:64];
	assign normal_z = s_tdata[95:80];
	assign index_from = s_tdata[109:96];
	assign index_to = s_tdata[123:110];

	// Stage 1: products and index terms
	logic               vld_s1;
	logic signed [31:0] px_s1, py_s1, pz_s1;
	logic [27:0]        n1sq_s1, n2sq_s1;
	logic [13:0]        diff_s1;
	logic [14:0]        sum_s1;
	logic               gt_s1;

	// Stage 2: clamped cosine
	logic               vld_s2;
	logic [Q_W-1:0]     c_s2;
	logic [27:0]        n1sq_s2, n2sq_s2, diffsq_s2;
	logic [29:0]        sq_s2;
	logic               gt_s2;

	// Stage 3: cos^2
	logic               vld_s3;
	logic [2*Q_W-1:0]   cc_s3;
	logic [Q_W-1:0]     c_s3;
	logic [27:0]        n1sq_s3, n2sq_s3, diffsq_s3;
	logic [29:0]        sq_s3;
	logic               gt_s3;

	// Stage 4: 1 - cos^2
	logic               vld_s4;
	logic [Q_W-1:0]     s_s4, c_s4;
	logic [27:0]        n1sq_s4, n2sq_s4, diffsq_s4;
	logic [29:0]        sq_s4;
	logic               gt_s4;

	// Stage 5: n1^2 (1 - cos^2)
	logic               vld_s5;
	logic [58:0]        num_s5;
	logic [Q_W-1:0]     c_s5;
	logic [27:0]        n2sq_s5, diffsq_s5;
	logic [29:0]        sq_s5;
	logic               gt_s5;

	logic signed [DOT_W-1:0] dot;
	logic signed [CW-1:0]    dot_ext;
	logic [CW-1:0]           d_cl, c_sh;

	assign dot = DOT_W'(px_s1) + DOT_W'(py_s1) + DOT_W'(pz_s1);
	assign dot_ext = CW'(dot);
	assign d_cl = (dot_ext < 0) ? '0 : (dot_ext > ONE2F) ? ONE2F : dot_ext;

	if (2 * F >= QBITS) begin : g_shr
		assign c_sh = d_cl >> (2 * F - QBITS);
	end else begin : g_shl
		assign c_sh = d_cl << (QBITS - 2 * F);
	end

	logic [2*Q_W-1:0] omc;
	assign omc = ONE_SQ - cc_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else if (en) begin
			vld_s1 <= s_tvalid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			px_s1 <= eye_x * normal_x;
			py_s1 <= eye_y * normal_y;
			pz_s1 <= eye_z * normal_z;
			n1sq_s1 <= index_from * index_from;
			n2sq_s1 <= index_to * index_to;
			diff_s1 <= (index_from > index_to) ? index_from - index_to : index_to - index_from;
			sum_s1 <= 15'(index_from) + 15'(index_to);
			gt_s1 <= index_from > index_to;

			c_s2 <= c_sh[Q_W-1:0];
			n1sq_s2 <= n1sq_s1;
			n2sq_s2 <= n2sq_s1;
			diffsq_s2 <= diff_s1 * diff_s1;
			sq_s2 <= sum_s1 * sum_s1;
			gt_s2 <= gt_s1;

			cc_s3 <= c_s2 * c_s2;
			c_s3 <= c_s2;
			n1sq_s3 <= n1sq_s2;
			n2sq_s3 <= n2sq_s2;
			diffsq_s3 <= diffsq_s2;
			sq_s3 <= sq_s2;
			gt_s3 <= gt_s2;

			s_s4 <= omc[QBITS+Q_W-1:QBITS];
			c_s4 <= c_s3;
			n1sq_s4 <= n1sq_s3;
			n2sq_s4 <= n2sq_s3;
			diffsq_s4 <= diffsq_s3;
			sq_s4 <= sq_s3;
			gt_s4 <= gt_s3;

			num_s5 <= n1sq_s4 * s_s4;
			c_s5 <= c_s4;
			n2sq_s5 <= n2sq_s4;
			diffsq_s5 <= diffsq_s4;
			sq_s5 <= sq_s4;
			gt_s5 <= gt_s4;
		end
	end

	// Total internal reflection: n1^2 (1 - cos^2) > n2^2, or a zero transmitted index.
	logic tir_s5;
	assign tir_s5 = gt_s5 && ((n2sq_s5 == '0) || (num_s5 > 59'({n2sq_s5, QBITS'(0)})));

	// sin^2 t and r0 divides run side by side with equal latency.
	logic           a_vld, b_vld;
	logic [Q_W-1:0] sin2t, r0_q;
	logic [1:0]     a_side;
	logic [Q_W:0]   b_side;

	srr_div_pipe #(
		.NUM_W (59),
		.DEN_W (28),
		.SIDE_W(2)
	) u_div_sin (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (vld_s5),
		.num      (num_s5),
		.den      (n2sq_s5),
		.side_in  ({tir_s5, gt_s5}),
		.out_valid(a_vld),
		.quo      (sin2t),
		.side_out (a_side)
	);

	srr_div_pipe #(
		.NUM_W (58),
		.DEN_W (30),
		.SIDE_W(Q_W + 1)
	) u_div_r0 (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (vld_s5),
		.num      ({diffsq_s5, QBITS'(0)}),
		.den      (sq_s5),
		.side_in  ({sq_s5 == '0, c_s5}),
		.out_valid(b_vld),
		.quo      (r0_q),
		.side_out (b_side)
	);

	srr_side_t      sq_side_in, sq_side_out;
	logic           r_vld;
	logic [Q_W-1:0] root;
	logic [Q_W-1:0] one_m_sin;

	assign one_m_sin = QONE - sin2t;
	assign sq_side_in = '{tir: a_side[1], gt: a_side[0], sq_zero: b_side[Q_W],
		c: b_side[Q_W-1:0], r0: r0_q};

	srr_sqrt_pipe u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (a_vld),
		.rad      (RAD_W'(one_m_sin) << QBITS),
		.side_in  (sq_side_in),
		.out_valid(r_vld),
		.root     (root),
		.side_out (sq_side_out)
	);

	// Back stages: 1 - cos, its fifth power, blend with r0.
	logic           vld_s7, vld_s8, vld_s9, vld_s10, vld_s11, vld_s12;
	logic [Q_W-1:0] t_s7, t_s8, t_s9, t_s10;
	logic [Q_W-1:0] p_s8, p_s9, p_s10, p_s11, m_s12;
	logic [Q_W-1:0] r0_s7, r0_s8, r0_s9, r0_s10, r0_s11, r0_s12;
	logic           tir_s7, tir_s8, tir_s9, tir_s10, tir_s11, tir_s12;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
			vld_s9 <= 1'b0;
			vld_s10 <= 1'b0;
			vld_s11 <= 1'b0;
			vld_s12 <= 1'b0;
		end else if (en) begin
			vld_s7 <= r_vld;
			vld_s8 <= vld_s7;
			vld_s9 <= vld_s8;
			vld_s10 <= vld_s9;
			vld_s11 <= vld_s10;
			vld_s12 <= vld_s11;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			t_s7 <= QONE - (sq_side_out.gt ? root : sq_side_out.c);
			r0_s7 <= sq_side_out.sq_zero ? '0 : sq_side_out.r0;
			tir_s7 <= sq_side_out.tir;

			p_s8 <= qmul(t_s7, t_s7);
			t_s8 <= t_s7;
			r0_s8 <= r0_s7;
			tir_s8 <= tir_s7;

			p_s9 <= qmul(p_s8, t_s8);
			t_s9 <= t_s8;
			r0_s9 <= r0_s8;
			tir_s9 <= tir_s8;

			p_s10 <= qmul(p_s9, t_s9);
			t_s10 <= t_s9;
			r0_s10 <= r0_s9;
			tir_s10 <= tir_s9;

			p_s11 <= qmul(p_s10, t_s10);
			r0_s11 <= r0_s10;
			tir_s11 <= tir_s10;

			m_s12 <= qmul(QONE - r0_s11, p_s11);
			r0_s12 <= r0_s11;
			tir_s12 <= tir_s11;
		end
	end

	logic [Q_W:0]            acc;
	logic [Q_W-REFL_SHIFT:0] scaled;
	logic [15:0]             res_val;

	assign acc = {1'b0, r0_s12} + {1'b0, m_s12};
	assign scaled = acc[Q_W:REFL_SHIFT];
	assign res_val = (tir_s12 || scaled > (Q_W - REFL_SHIFT + 1)'(REFL_ONE)) ? REFL_ONE
		: scaled[15:0];

	// Output register plus skid entry.
	logic        out_v_q, skid_v_q, out_tir_q, skid_tir_q;
	logic [15:0] out_data_q, skid_data_q;
	logic        push, pop;

	assign en = !skid_v_q;
	assign s_tready = en;
	assign push = en && vld_s12;
	assign pop = out_v_q && m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (skid_v_q) begin
			if (pop) begin
				skid_v_q <= 1'b0;
			end
		end else if (push) begin
			// Park the result when the output holds one that is not being taken.
			if (out_v_q && !pop) begin
				skid_v_q <= 1'b1;
			end else begin
				out_v_q <= 1'b1;
			end
		end else if (pop) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_v_q) begin
			if (pop) begin
				out_data_q <= skid_data_q;
				out_tir_q <= skid_tir_q;
			end
		end else if (push) begin
			if (out_v_q && !pop) begin
				skid_data_q <= res_val;
				skid_tir_q <= tir_s12;
			end else begin
				out_data_q <= res_val;
				out_tir_q <= tir_s12;
			end
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata = out_data_q;
	assign m_tuser = out_tir_q;

`ifndef SYNTH
	a_div_align: assert property (@(posedge clk) disable iff (!arst_n) a_vld == b_vld)
		else $error("divider lanes out of step");
	a_skid_order: assert property (@(posedge clk) disable iff (!arst_n) skid_v_q |-> out_v_q)
		else $error("skid entry held without output entry");
	a_tir_value: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> m_tdata == REFL_ONE)
		else $error("total internal reflection without full reflectance");
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata <= REFL_ONE)
		else $error("reflectance above one");
`endif

endmodule

`default_nettype wire

FILE: dv/schlick_reflectance_unit_tb.sv
// Stream testbench for the Schlick reflectance unit: random and corner requests checked against a built-in predictor.
`timescale 1ns / 1ps
`default_nettype none

module schlick_reflectance_unit_tb;
	import srr_pkg::*;

	localparam int VFB = 14;
	localparam int LATENCY = 73;
	localparam int CYCLE_LIMIT = 400000;
	localparam logic [15:0] V_ONE = 16'sd16384;

	typedef struct packed {
		logic [15:0] refl;
		logic        tir;
	} reflect_t;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [127:0] s_tdata;
	logic         m_tvalid;
	logic         m_tready;
	logic [15:0]  m_tdata;
	logic [0:0]   m_tuser;

	logic [127:0] request_q[$];
	reflect_t     expected_q[$];
	int           errors = 0;
	int           results_seen = 0;
	int           tir_seen = 0;
	int           cycles = 0;
	bit           quiet = 0;
	bit           hold_for_drain = 0;
	int           send_gap = 0;
	int           recv_gap = 0;

	schlick_reflectance_unit #(.VECTOR_FRAC_BITS(VFB)) u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	function automatic logic [63:0] floor_sqrt(input logic [63:0] v);
		logic [63:0] r;
		logic [63:0] b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic logic [63:0] fx_mul(input logic [63:0] a, input logic [63:0] b);
		logic [127:0] pr;
		pr = a * b;
		return pr[93:30];
	endfunction

	function automatic reflect_t predict_reflectance(input logic [127:0] d);
		longint dot;
		logic [63:0] n1, n2, dc, c, s, num, den, sin2t, r0, t, p, res, diff, sq;
		logic [127:0] cc;
		reflect_t o;
		dot = longint'($signed(d[15:0])) * longint'($signed(d[63:48]))
			+ longint'($signed(d[31:16])) * longint'($signed(d[79:64]))
			+ longint'($signed(d[47:32])) * longint'($signed(d[95:80]));
		n1 = 64'(d[109:96]);
		n2 = 64'(d[123:110]);
		if (dot < 0) dc = 0;
		else if (dot > (longint'(1) << (2 * VFB))) dc = 64'd1 << (2 * VFB);
		else dc = dot;
		c = dc << (30 - 2 * VFB);
		if (n1 > n2) begin
			cc = c * c;
			s = 64'(((128'd1 << 60) - cc) >> 30);
			num = n1 * n1 * s;
			den = n2 * n2;
			if (den == 0 || num > (den << 30)) begin
				o.refl = 16'd32768;
				o.tir = 1'b1;
				return o;
			end
			sin2t = num / den;
			c = floor_sqrt(((64'd1 << 30) - sin2t) << 30);
			if (c > (64'd1 << 30)) c = 64'd1 << 30;
		end
		diff = n1 > n2 ? n1 - n2 : n2 - n1;
		sq = (n1 + n2) * (n1 + n2);
		r0 = sq == 0 ? 0 : ((diff * diff) << 30) / sq;
		if (r0 > (64'd1 << 30)) r0 = 64'd1 << 30;
		t = (64'd1 << 30) - c;
		p = fx_mul(t, t);
		p = fx_mul(p, t);
		p = fx_mul(p, t);
		p = fx_mul(p, t);
		res = (r0 + fx_mul((64'd1 << 30) - r0, p)) >> 15;
		if (res > 32768) res = 32768;
		o.refl = res[15:0];
		o.tir = 1'b0;
		return o;
	endfunction

	function automatic logic [127:0] pack_request(input logic [15:0] ex, ey, ez, nx, ny, nz,
			input logic [13:0] n1, n2);
		return {4'd0, n2, n1, nz, ny, nx, ez, ey, ex};
	endfunction

	function automatic void queue_request(input logic [127:0] r);
		request_q.insert(request_q.size(), r);
	endfunction

	function automatic logic [15:0] rand_comp();
		return 16'($urandom_range(32768) - 16384);
	endfunction

	function automatic logic [13:0] rand_index();
		int k;
		k = $urandom_range(9);
		if (k == 0) return 14'($urandom_range(4096, 16383));
		if (k < 3) return 14'($urandom_range(16383));
		return 14'($urandom_range(4096, 8192));
	endfunction

	// Roughly unit vectors: one dominant axis, small others, random signs; about one in five is fully random.
	function automatic logic [127:0] rand_request();
		logic [15:0] v[6];
		int a;
		if ($urandom_range(4) == 0) begin
			foreach (v[i]) v[i] = rand_comp();
		end else begin
			for (int k = 0; k < 2; k++) begin
				a = $urandom_range(2);
				for (int j = 0; j < 3; j++)
					v[3 * k + j] = 16'($urandom_range(6000) - 3000);
				v[3 * k + a] = 16'($urandom_range(13000, 16384));
				if ($urandom_range(3) == 0) v[3 * k + a] = -v[3 * k + a];
			end
		end
		return pack_request(v[0], v[1], v[2], v[3], v[4], v[5], rand_index(), rand_index());
	endfunction

	// Driver: issue pending requests with random idle bursts.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
		end else begin
			if (s_tvalid && s_tready) begin
				expected_q.insert(expected_q.size(), predict_reflectance(s_tdata));
				void'(request_q.pop_front());
			end
			if (s_tvalid && !(s_tready)) begin
				// hold the request
			end else if (send_gap > 0) begin
				send_gap <= send_gap - 1;
				s_tvalid <= 1'b0;
			end else if (!quiet && $urandom_range(14) == 0) begin
				send_gap <= $urandom_range(1, 18);
				s_tvalid <= 1'b0;
			end else if (hold_for_drain || request_q.size() == 0) begin
				s_tvalid <= 1'b0;
			end else begin
				s_tvalid <= 1'b1;
				s_tdata <= request_q[0];
			end
		end
	end

	// Monitor: random back-pressure and in-order comparison.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				reflect_t e;
				if (expected_q.size() == 0) begin
					$error("unexpected result: reflectance_value %0d", m_tdata);
					errors++;
				end else begin
					e = expected_q.pop_front();
					if (m_tdata !== e.refl) begin
						$error("reflectance_value expected %0d actual %0d", e.refl, m_tdata);
						errors++;
					end
					if (m_tuser[0] !== e.tir) begin
						$error("total_internal expected %0d actual %0d", e.tir, m_tuser[0]);
						errors++;
					end
					if (e.tir) tir_seen++;
				end
				results_seen++;
			end
			if (recv_gap > 0) begin
				recv_gap <= recv_gap - 1;
				m_tready <= 1'b0;
			end else if (!quiet && $urandom_range(12) == 0) begin
				recv_gap <= $urandom_range(1, 18);
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("RESULT: ERROR");
			$finish;
		end
	end

	initial begin
		logic [13:0] idx[4];
		arst_n = 1'b0;
		idx = '{14'd4096, 14'd16383, 14'd0, 14'd6144};
		// directed: extreme components, aligned / opposed / grazing, both index orders
		queue_request(pack_request(V_ONE, 0, 0, V_ONE, 0, 0, 14'd4096, 14'd6144));
		queue_request(pack_request(V_ONE, 0, 0, -V_ONE, 0, 0, 14'd6144, 14'd4096));
		queue_request(pack_request(V_ONE, 0, 0, 0, V_ONE, 0, 14'd6144, 14'd4096));
		queue_request(pack_request(V_ONE, 0, 0, 0, V_ONE, 0, 14'd4096, 14'd6144));
		queue_request(pack_request(V_ONE, V_ONE, V_ONE, V_ONE, V_ONE, V_ONE,
			14'd16383, 14'd4096));
		queue_request(pack_request(-V_ONE, -V_ONE, -V_ONE, -V_ONE, -V_ONE, -V_ONE,
			14'd4096, 14'd16383));
		queue_request(pack_request(16'h8000, 16'h7fff, 16'h8000, 16'h8000, 16'h7fff,
			16'h8000, 14'h3fff, 14'h3fff));
		queue_request(pack_request(16'd11585, 0, 16'd11585, 0, 0, V_ONE,
			14'd6144, 14'd4096));
		queue_request(pack_request(16'd15000, 0, 16'd6600, V_ONE, 0, 0,
			14'd6144, 14'd4096));
		foreach (idx[i])
			foreach (idx[j])
				queue_request(pack_request(16'd8000, 16'd8000, 16'd8000, 16'd9000,
					16'd9000, 16'd9000, idx[i], idx[j]));
		repeat (1525) queue_request(rand_request());
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		// drain once midway with the sender held off
		wait (request_q.size() < 800);
		@(posedge clk);
		hold_for_drain <= 1'b1;
		wait (expected_q.size() == 0 && !s_tvalid);
		repeat (LATENCY + 10) @(posedge clk);
		hold_for_drain <= 1'b0;
		wait (request_q.size() < 200);
		quiet <= 1'b1;
		wait (request_q.size() == 0 && !s_tvalid);
		wait (expected_q.size() == 0);
		repeat (LATENCY + 20) @(posedge clk);
		$display("covered %0d results, %0d with total internal reflection", results_seen, tir_seen);
		$display("directed corners, random vectors and indices, bursty idling on both sides");
		if (errors == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule

`default_nettype wire
